// File: rtl/jci_pkg.sv
// Shared types, constants and the jet table function for the jet colormap core.
// No dependencies; every other file in rtl/ imports this package.
package jci_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int TABLE_ENTRIES = 64;
	localparam int N1            = TABLE_ENTRIES - 1;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int NUM_CH        = 3;
	localparam int ENTRY_W       = 5;
	localparam int CH_W          = 8;
	localparam int SAMPLE_W      = 32;
	localparam int NUM_W         = SAMPLE_W + 1;
	localparam int DEN_W         = SAMPLE_W;
	localparam int V_W           = FRACTION_BITS + 1;
	localparam int T_W           = V_W + IDX_W;
	localparam int C16_W         = FRACTION_BITS + ENTRY_W;
	localparam int RND_W         = C16_W + CH_W + 1;
	localparam int CFG_IDX_W     = 2;

	localparam logic [DEN_W-1:0] RAW_DEN    = DEN_W'(2 ** FRACTION_BITS);
	localparam logic [V_W-1:0]   V_ONE      = V_W'(2 ** FRACTION_BITS);
	localparam logic [RND_W-1:0] ROUND_BIAS = RND_W'(8) << FRACTION_BITS;
	localparam logic [CH_W-1:0]  CH_MAX     = '1;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd2;

	typedef enum logic [1:0] {
		MODE_RAW_EDGE   = 2'd0,
		MODE_NORM_EDGE  = 2'd1,
		MODE_NORM_CLAMP = 2'd2,
		MODE_RESERVED   = 2'd3
	} color_mode_t;

	typedef logic [ENTRY_W-1:0] entry_t;

	// per-transaction control that rides along the pipeline
	typedef struct packed {
		logic valid;
		logic black;    // edge mode, value at or below 0
		logic white;    // edge mode, value at or above 1
		logic bypass;   // quotient not needed, value saturated
		logic sat_one;  // saturated value is 1 (else 0)
	} item_ctl_t;

	// jet entry in sixteenths; evaluated only on constants (table build)
	function automatic entry_t jet_entry(input int ch, input int i);
		int rise;
		int fall;
		int p;
		int lo;
		int hi;
		int m;
		rise = (ch == 0) ? 23 : (ch == 1) ? 7 : -9;
		fall = (ch == 0) ? 71 : (ch == 1) ? 55 : 39;
		p    = 63 * i;
		lo   = p - rise * N1;
		hi   = fall * N1 - p;
		m    = (lo < hi) ? lo : hi;
		if (m < 0)
			m = 0;
		if (m > 16 * N1)
			m = 16 * N1;
		return ENTRY_W'((m + N1 / 2) / N1);
	endfunction

endpackage

// File: rtl/jci_front.sv
// Front end: forms numerator and denominator, then classifies the value.
// Depends on jci_pkg.
module jci_front import jci_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  color_mode_t                color_mode,
	input  logic signed [SAMPLE_W-1:0] range_low,
	input  logic signed [SAMPLE_W-1:0] range_high,
	output item_ctl_t                  ctl_s2,
	output logic [DEN_W-1:0]           rem_s2,
	output logic [DEN_W-1:0]           den_s2
);

	logic signed [NUM_W-1:0] sample_x, low_x, high_x;
	logic signed [NUM_W-1:0] diff_pos, diff_neg, span_pos, span_neg;
	logic signed [NUM_W-1:0] num_d;
	logic [DEN_W-1:0]        den_d;
	logic                    norm, clamp_d, span_zero, span_neg_flag;

	logic                    valid_s1, clamp_s1;
	logic signed [NUM_W-1:0] num_s1;
	logic [DEN_W-1:0]        den_s1;
	logic                    le_zero, ge_den;

	assign sample_x = {sample[SAMPLE_W-1], sample};
	assign low_x    = {range_low[SAMPLE_W-1], range_low};
	assign high_x   = {range_high[SAMPLE_W-1], range_high};

	assign diff_pos = sample_x - low_x;
	assign diff_neg = low_x - sample_x;
	assign span_pos = high_x - low_x;
	assign span_neg = low_x - high_x;

	assign span_zero     = (range_high == range_low);
	assign span_neg_flag = span_pos[NUM_W-1];
	assign norm          = (color_mode != MODE_RAW_EDGE);
	assign clamp_d       = (color_mode == MODE_NORM_CLAMP) || (color_mode == MODE_RESERVED);

	// reversed range flips both signs; empty range forces 0
	always_comb begin
		if (!norm) begin
			num_d = sample_x;
			den_d = RAW_DEN;
		end else if (span_zero) begin
			num_d = '0;
			den_d = DEN_W'(1);
		end else if (span_neg_flag) begin
			num_d = diff_neg;
			den_d = span_neg[DEN_W-1:0];
		end else begin
			num_d = diff_pos;
			den_d = span_pos[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		clamp_s1 <= clamp_d;
		num_s1   <= num_d;
		den_s1   <= den_d;
	end

	assign le_zero = num_s1[NUM_W-1] || (num_s1 == '0);
	assign ge_den  = !num_s1[NUM_W-1] && (num_s1[DEN_W-1:0] >= den_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.valid   <= valid_s1;
			ctl_s2.black   <= !clamp_s1 && le_zero;
			ctl_s2.white   <= !clamp_s1 && !le_zero && ge_den;
			ctl_s2.bypass  <= le_zero || ge_den;
			ctl_s2.sat_one <= !le_zero && ge_den;
		end
	end

	always_ff @(posedge clk) begin
		rem_s2 <= num_s1[DEN_W-1:0];
		den_s2 <= den_s1;
	end

endmodule

// File: rtl/jci_divider.sv
// Pipelined restoring divider: one quotient bit per stage, FRACTION_BITS stages.
// Depends on jci_pkg.
module jci_divider import jci_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  item_ctl_t                in_ctl,
	input  logic [DEN_W-1:0]         in_rem,
	input  logic [DEN_W-1:0]         in_den,
	output item_ctl_t                out_ctl,
	output logic [FRACTION_BITS-1:0] out_quo
);

	item_ctl_t                ctl_s [FRACTION_BITS+1];
	logic [DEN_W-1:0]         rem_s [FRACTION_BITS+1];
	logic [DEN_W-1:0]         den_s [FRACTION_BITS+1];
	logic [FRACTION_BITS-1:0] quo_s [FRACTION_BITS+1];

	assign ctl_s[0] = in_ctl;
	assign rem_s[0] = in_rem;
	assign den_s[0] = in_den;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_stage
		logic [DEN_W:0]   shifted;
		logic [DEN_W:0]   diff;
		logic             take;

		// remainder stays below den, so the doubled value fits DEN_W+1 bits
		assign shifted = {rem_s[k], 1'b0};
		assign diff    = shifted - {1'b0, den_s[k]};
		assign take    = (shifted >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= {quo_s[k][FRACTION_BITS-2:0], take};
		end
	end

	assign out_ctl = ctl_s[FRACTION_BITS];
	assign out_quo = quo_s[FRACTION_BITS];

endmodule

// File: rtl/jci_table_rom.sv
// Jet table ROM, three channels, two read ports with registered data.
// Depends on jci_pkg (jet_entry builds the contents).
module jci_table_rom import jci_pkg::*; (
	input  logic                     clk,
	input  logic [IDX_W-1:0]         rd_addr_a,
	input  logic [IDX_W-1:0]         rd_addr_b,
	output entry_t [NUM_CH-1:0]      rd_data_a,
	output entry_t [NUM_CH-1:0]      rd_data_b
);

	entry_t tbl [NUM_CH][TABLE_ENTRIES];

	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_ent
			assign tbl[c][i] = jet_entry(c, i);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CH; c++) begin
			rd_data_a[c] <= tbl[c][rd_addr_a];
			rd_data_b[c] <= tbl[c][rd_addr_b];
		end
	end

endmodule

// File: rtl/jci_blend.sv
// Interpolates two neighbor entries per channel and rounds to 8 bits.
// Depends on jci_pkg.
module jci_blend import jci_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  item_ctl_t                in_ctl,
	input  logic [FRACTION_BITS-1:0] in_frac,
	input  entry_t [NUM_CH-1:0]      in_lo,
	input  entry_t [NUM_CH-1:0]      in_hi,
	output logic                     done,
	output logic [CH_W-1:0]          red,
	output logic [CH_W-1:0]          green,
	output logic [CH_W-1:0]          blue
);

	logic [V_W-1:0]   wlo;
	logic [C16_W-1:0] c16_d   [NUM_CH];
	logic [C16_W-1:0] c16_s21 [NUM_CH];
	item_ctl_t        ctl_s21;
	logic [CH_W-1:0]  chan_d  [NUM_CH];
	logic             done_q;
	logic [CH_W-1:0]  red_q, green_q, blue_q;

	assign wlo = V_ONE - V_W'(in_frac);

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			c16_d[c] = C16_W'(in_lo[c]) * C16_W'(wlo) + C16_W'(in_hi[c]) * C16_W'(in_frac);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s21 <= '0;
		end else begin
			ctl_s21 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CH; c++) begin
			c16_s21[c] <= c16_d[c];
		end
	end

	// times 255 as shift-minus, plus half, drop 4+F bits
	always_comb begin
		logic [RND_W-1:0] acc;
		logic [CH_W:0]    o9;
		for (int c = 0; c < NUM_CH; c++) begin
			acc = (RND_W'(c16_s21[c]) << CH_W) - RND_W'(c16_s21[c]) + ROUND_BIAS;
			o9  = acc[FRACTION_BITS+4 +: CH_W+1];
			if (ctl_s21.black)
				chan_d[c] = '0;
			else if (ctl_s21.white)
				chan_d[c] = CH_MAX;
			else if (o9[CH_W])
				chan_d[c] = CH_MAX;
			else
				chan_d[c] = o9[CH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s21.valid;
		end
	end

	always_ff @(posedge clk) begin
		red_q   <= chan_d[0];
		green_q <= chan_d[1];
		blue_q  <= chan_d[2];
	end

	assign done  = done_q;
	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

endmodule

// File: rtl/jet_colormap_interpolator_core.sv
// Top level of the jet false-color core: config registers and pipeline glue.
// Depends on jci_pkg, jci_front, jci_divider, jci_table_rom, jci_blend.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------
//   input     | start, busy          | sample
//   result    | done (1-cycle pulse) | red, green, blue
//   config    | cfg_wr_en            | cfg_index, cfg_wr_data
//
// One transaction is taken per clock; busy is always low, so a transaction
// is accepted at every edge where start is high.
// Done follows acceptance through the front-end registers, the 16-stage
// quotient pipeline, the index register, the registered table ROM read and
// the blend product and output registers.
// Reset clears the config registers to raw edge mode, low 0, high 65536, and
// empties the pipeline. The receiver cannot stall; results are never held.
module jet_colormap_interpolator_core import jci_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       done,
	output logic [CH_W-1:0]            red,
	output logic [CH_W-1:0]            green,
	output logic [CH_W-1:0]            blue,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [SAMPLE_W-1:0]        cfg_wr_data
);

	color_mode_t                color_mode_q;
	logic signed [SAMPLE_W-1:0] range_low_q;
	logic signed [SAMPLE_W-1:0] range_high_q;

	logic                       accept;
	item_ctl_t                  ctl_s2, ctl_s18, ctl_s19, ctl_s20;
	logic [DEN_W-1:0]           rem_s2, den_s2;
	logic [FRACTION_BITS-1:0]   quo_s18;

	logic [V_W-1:0]             v_d;
	logic [T_W-1:0]             t_d;
	logic [T_W-FRACTION_BITS-1:0] idx_wide;
	logic [IDX_W-1:0]           idx_d, nidx_d;

	logic [IDX_W-1:0]           idx_s19, nidx_s19;
	logic [FRACTION_BITS-1:0]   frac_s19, frac_s20;
	entry_t [NUM_CH-1:0]        lo_s20, hi_s20;

	// fully pipelined: never back-pressures the sender
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// config writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= MODE_RAW_EDGE;
			range_low_q  <= '0;
			range_high_q <= SAMPLE_W'(65536);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COLOR_MODE: color_mode_q <= color_mode_t'(cfg_wr_data[1:0]);
				REG_RANGE_LOW:  range_low_q  <= cfg_wr_data;
				REG_RANGE_HIGH: range_high_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	jci_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.sample     (sample),
		.color_mode (color_mode_q),
		.range_low  (range_low_q),
		.range_high (range_high_q),
		.ctl_s2     (ctl_s2),
		.rem_s2     (rem_s2),
		.den_s2     (den_s2)
	);

	jci_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_s2),
		.in_rem  (rem_s2),
		.in_den  (den_s2),
		.out_ctl (ctl_s18),
		.out_quo (quo_s18)
	);

	// value -> index and fraction; v*N1 is a constant multiply
	always_comb begin
		if (ctl_s18.bypass)
			v_d = ctl_s18.sat_one ? V_ONE : '0;
		else
			v_d = {1'b0, quo_s18};
		t_d      = T_W'(v_d) * T_W'(N1);
		idx_wide = t_d[T_W-1:FRACTION_BITS];
		// top index: both neighbors use the last entry
		if (idx_wide >= (T_W-FRACTION_BITS)'(N1)) begin
			idx_d  = IDX_W'(N1);
			nidx_d = IDX_W'(N1);
		end else begin
			idx_d  = idx_wide[IDX_W-1:0];
			nidx_d = idx_wide[IDX_W-1:0] + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s19 <= '0;
			ctl_s20 <= '0;
		end else begin
			ctl_s19 <= ctl_s18;
			ctl_s20 <= ctl_s19;
		end
	end

	always_ff @(posedge clk) begin
		idx_s19  <= idx_d;
		nidx_s19 <= nidx_d;
		frac_s19 <= t_d[FRACTION_BITS-1:0];
		frac_s20 <= frac_s19;
	end

	jci_table_rom u_rom (
		.clk       (clk),
		.rd_addr_a (idx_s19),
		.rd_addr_b (nidx_s19),
		.rd_data_a (lo_s20),
		.rd_data_b (hi_s20)
	);

	jci_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_s20),
		.in_frac (frac_s20),
		.in_lo   (lo_s20),
		.in_hi   (hi_s20),
		.done    (done),
		.red     (red),
		.green   (green),
		.blue    (blue)
	);

endmodule
